@@ rtl/bpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Binomial pyramid reduce package
// Shared pixel types, register indexes, reset values and the binomial
// filter functions used by both the horizontal and the vertical pass.
// ----------------------------------------------------------------------------
package bpr_pkg;

    localparam int BPR_MAX_WIDTH = 2048;

    localparam int BPR_CFG_INDEX_W = 2;
    localparam int BPR_CFG_DATA_W  = 12;
    localparam int BPR_ROW_W       = 12;

    localparam logic [BPR_CFG_INDEX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [BPR_CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [BPR_CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam int BPR_RADIUS_RESET = 2;
    localparam int BPR_WIDTH_RESET  = 640;
    localparam int BPR_HEIGHT_RESET = 480;
    localparam int BPR_MIN_SIZE     = 5;

    typedef logic [23:0] pix_t;

    typedef struct packed {
        pix_t       hval;
        logic [1:0] row_slot;
        logic       wr_en;
        logic       emit;
        logic       row_end;
        logic       frame_end;
    } bpr_item_t;

    // Taps 1,2,1 with a floor shift by two, per 8-bit channel.
    function automatic pix_t blend3(input pix_t a, input pix_t b, input pix_t c);
        pix_t       res;
        logic [9:0] s;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            s = 10'(a[ch*8 +: 8]) + (10'(b[ch*8 +: 8]) << 1) + 10'(c[ch*8 +: 8]);
            res[ch*8 +: 8] = s[9:2];
        end
        return res;
    endfunction

    // Taps 1,4,6,4,1 with a floor shift by four, per 8-bit channel.
    function automatic pix_t blend5(input pix_t a, input pix_t b, input pix_t c,
                                    input pix_t d, input pix_t e);
        pix_t        res;
        logic [11:0] s;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            s = 12'(a[ch*8 +: 8]) + (12'(b[ch*8 +: 8]) << 2)
              + (12'(c[ch*8 +: 8]) << 2) + (12'(c[ch*8 +: 8]) << 1)
              + (12'(d[ch*8 +: 8]) << 2) + 12'(e[ch*8 +: 8]);
            res[ch*8 +: 8] = s[11:4];
        end
        return res;
    endfunction

endpackage

@@ rtl/binomial_pyramid_reduce_top.sv @@
// ----------------------------------------------------------------------------
// Binomial pyramid reduce, top level
// Takes one RGB pixel per clock in raster order while s_ready is high and
// returns the one-level pyramid reduction: a separable binomial filter (3 or
// 5 taps) decimated by two in both directions, with row and frame end flags
// on the results. An accepted pixel is registered in the input stage; its
// result, if it has one, is loaded into the output register when that
// register is free. While a word waits there, the input keeps flowing until
// the next pixel with a result reaches the filter stage. The line store is
// four single-write, single-read RAMs of MAX_WIDTH words; all four are read
// per accepted pixel and at most the one for its row is written. A write to
// the radius, width or height register restarts the frame at its first pixel.
// ----------------------------------------------------------------------------
module binomial_pyramid_reduce_top import bpr_pkg::*; #(
    parameter int MAX_WIDTH = BPR_MAX_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_red_in,
    input  logic [7:0]                 s_green_in,
    input  logic [7:0]                 s_blue_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_red_out,
    output logic [7:0]                 m_green_out,
    output logic [7:0]                 m_blue_out,
    output logic                       m_row_end,
    output logic                       m_frame_end,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [BPR_CFG_INDEX_W-1:0] cfg_index,
    input  logic [BPR_CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > BPR_CFG_DATA_W) ? WW : BPR_CFG_DATA_W;
    localparam int WIDTH_RST = (BPR_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : BPR_WIDTH_RESET;

    logic                 rad2_reg, rad2_next;
    logic [WW-1:0]        width_reg, width_next;
    logic [BPR_ROW_W-1:0] height_reg, height_next;
    logic                 cfg_wr, cfg_restart;
    logic [EW-1:0]        data_ext;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 s1_valid, s1_advance;
    bpr_item_t            s1_item;
    logic [AW-1:0]        s1_addr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign data_ext  = EW'(cfg_data);

    always_comb begin
        rad2_next   = rad2_reg;
        width_next  = width_reg;
        height_next = height_reg;
        cfg_restart = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_index)
                CFG_RADIUS: begin
                    rad2_next   = (cfg_data[1:0] != 2'd1);
                    cfg_restart = 1'b1;
                end
                CFG_WIDTH: begin
                    if (data_ext < EW'(BPR_MIN_SIZE)) begin
                        width_next = WW'(BPR_MIN_SIZE);
                    end else if (data_ext > EW'(MAX_WIDTH)) begin
                        width_next = WW'(MAX_WIDTH);
                    end else begin
                        width_next = WW'(data_ext);
                    end
                    cfg_restart = 1'b1;
                end
                CFG_HEIGHT: begin
                    if (cfg_data < BPR_CFG_DATA_W'(BPR_MIN_SIZE)) begin
                        height_next = BPR_ROW_W'(BPR_MIN_SIZE);
                    end else begin
                        height_next = cfg_data;
                    end
                    cfg_restart = 1'b1;
                end
                default: begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad2_reg   <= (BPR_RADIUS_RESET != 1);
            width_reg  <= WW'(WIDTH_RST);
            height_reg <= BPR_ROW_W'(BPR_HEIGHT_RESET);
        end else begin
            rad2_reg   <= rad2_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    bpr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .cfg_restart (cfg_restart),
        .cfg_rad2    (rad2_reg),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .s1_addr     (s1_addr),
        .s1_advance  (s1_advance)
    );

    bpr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_rad2    (rad2_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .s1_addr     (s1_addr),
        .s1_advance  (s1_advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

endmodule

@@ rtl/bpr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module bpr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bpr_front.sv @@
// ----------------------------------------------------------------------------
// Binomial pyramid reduce, input stage
// Raster counters, the horizontal pixel window and the horizontal filter.
// Each accepted pixel is registered together with its line store address
// and its output flags; the line store read is issued at the same edge.
// ----------------------------------------------------------------------------
module bpr_front import bpr_pkg::*; #(
    parameter int MAX_WIDTH = BPR_MAX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_red_in,
    input  logic [7:0]                       s_green_in,
    input  logic [7:0]                       s_blue_in,
    input  logic                             cfg_restart,
    input  logic                             cfg_rad2,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   cfg_width,
    input  logic [BPR_ROW_W-1:0]             cfg_height,
    output logic                             rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    output logic                             s1_valid,
    output bpr_item_t                        s1_item,
    output logic [$clog2(MAX_WIDTH)-1:0]     s1_addr,
    input  logic                             s1_advance
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [AW-1:0]        col_reg, col_next;
    logic [BPR_ROW_W-1:0] row_reg, row_next;
    logic                 s1_valid_reg, s1_valid_next;
    bpr_item_t            s1_item_reg, item_next;
    logic [AW-1:0]        s1_addr_reg;
    pix_t                 win_reg [4];
    pix_t                 cur;
    logic                 accept;
    logic [AW-1:0]        span_c, rad_c;
    logic [BPR_ROW_W-1:0] span_r;
    logic                 hpass, vpass;
    logic [WW:0]          col_inc;
    logic [BPR_ROW_W:0]   row_inc;

    assign cur    = {s_blue_in, s_green_in, s_red_in};
    assign s_ready = !s1_valid_reg || s1_advance;
    assign accept = s_valid && s_ready;

    assign span_c = cfg_rad2 ? AW'(4) : AW'(2);
    assign rad_c  = cfg_rad2 ? AW'(2) : AW'(1);
    assign span_r = cfg_rad2 ? BPR_ROW_W'(4) : BPR_ROW_W'(2);

    assign hpass   = col_reg >= span_c;
    assign vpass   = row_reg >= span_r;
    assign rd_en   = accept;
    assign rd_addr = col_reg - rad_c;

    assign col_inc = (WW+1)'(col_reg) + (WW+1)'(1);
    assign row_inc = (BPR_ROW_W+1)'(row_reg) + (BPR_ROW_W+1)'(1);

    always_comb begin
        item_next.hval      = cfg_rad2 ? blend5(win_reg[3], win_reg[2], win_reg[1],
                                                win_reg[0], cur)
                                       : blend3(win_reg[1], win_reg[0], cur);
        item_next.row_slot  = row_reg[1:0];
        item_next.wr_en     = hpass;
        item_next.emit      = hpass && vpass && !col_reg[0] && !row_reg[0];
        item_next.row_end   = (col_inc + (WW+1)'(1)) >= {1'b0, cfg_width};
        item_next.frame_end = item_next.row_end
                           && ((row_inc + (BPR_ROW_W+1)'(1)) >= {1'b0, cfg_height});
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_inc >= {1'b0, cfg_width}) begin
                col_next = '0;
                if (row_inc >= {1'b0, cfg_height}) begin
                    row_next = '0;
                end else begin
                    row_next = row_inc[BPR_ROW_W-1:0];
                end
            end else begin
                col_next = col_inc[AW-1:0];
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg[3]  <= win_reg[2];
            win_reg[2]  <= win_reg[1];
            win_reg[1]  <= win_reg[0];
            win_reg[0]  <= cur;
            s1_item_reg <= item_next;
            s1_addr_reg <= rd_addr;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign s1_addr  = s1_addr_reg;

endmodule

@@ rtl/bpr_back.sv @@
// ----------------------------------------------------------------------------
// Binomial pyramid reduce, output stage
// Four line store RAMs hold the horizontal results of the last four rows.
// The vertical filter combines them with the current horizontal result and
// loads the output register; the new horizontal result is written back.
// ----------------------------------------------------------------------------
module bpr_back import bpr_pkg::*; #(
    parameter int MAX_WIDTH = BPR_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_rad2,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         s1_valid,
    input  bpr_item_t                    s1_item,
    input  logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
    output logic                         s1_advance,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_red_out,
    output logic [7:0]                   m_green_out,
    output logic [7:0]                   m_blue_out,
    output logic                         m_row_end,
    output logic                         m_frame_end
);

    pix_t       line_data [4];
    pix_t       vval;
    logic [1:0] base;
    logic       out_free;
    logic       m_valid_reg, m_valid_next;
    pix_t       m_pix_reg;
    logic       m_row_end_reg, m_frame_end_reg;

    for (genvar i = 0; i < 4; i++) begin : g_line
        bpr_ram #(
            .WIDTH (24),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (s1_advance && s1_item.wr_en && (s1_item.row_slot == 2'(i))),
            .wr_addr (s1_addr),
            .wr_data (s1_item.hval),
            .rd_en   (rd_en),
            .rd_addr (rd_addr),
            .rd_data (line_data[i])
        );
    end

    assign base = s1_item.row_slot;

    always_comb begin
        if (cfg_rad2) begin
            vval = blend5(line_data[base], line_data[base + 2'd1], line_data[base + 2'd2],
                          line_data[base + 2'd3], s1_item.hval);
        end else begin
            vval = blend3(line_data[base + 2'd2], line_data[base + 2'd3], s1_item.hval);
        end
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid && (!s1_item.emit || out_free);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_advance && s1_item.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_item.emit) begin
            m_pix_reg       <= vval;
            m_row_end_reg   <= s1_item.row_end;
            m_frame_end_reg <= s1_item.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_pix_reg[7:0];
    assign m_green_out = m_pix_reg[15:8];
    assign m_blue_out  = m_pix_reg[23:16];
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

@@ rtl/bpr_checker.sv @@
// ----------------------------------------------------------------------------
// Binomial pyramid reduce, port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module bpr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red_out,
    input logic [7:0] m_green_out,
    input logic [7:0] m_blue_out,
    input logic       m_row_end,
    input logic       m_frame_end,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // A stalled output word holds its value and flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out)
            && $stable(m_blue_out) && $stable(m_row_end) && $stable(m_frame_end))
        else $error("stalled output word changed");

    // The last word of a frame also closes its row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_row_end)
        else $error("frame end without row end");

    // With the output register empty, the input side is never blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output is empty");

    // No output word is left over from before a reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_valid)
        else $error("output valid right after reset");

    // The configuration port never stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind binomial_pyramid_reduce_top bpr_checker u_checker (.*);
